// ----- rtl/core/tdt_pkg.sv -----
// ----------------------------------------------------------------------------
// tdt_pkg: shared types and constants of the tap / double-tap detector
// Command and event codes, register indexes, reset values and the
// structures passed between the detector's modules.
// ----------------------------------------------------------------------------
package tdt_pkg;

  localparam int unsigned MagW    = 16;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned CfgW    = 16;
  localparam int unsigned CfgIdxW = 3;

  typedef logic [1:0] cmd_t;
  localparam cmd_t CMD_SAMPLE  = 2'd0;
  localparam cmd_t CMD_CHECK   = 2'd1;
  localparam cmd_t CMD_RESTART = 2'd2;

  typedef logic [1:0] tap_ev_t;
  localparam tap_ev_t EV_NONE   = 2'd0;
  localparam tap_ev_t EV_SINGLE = 2'd1;
  localparam tap_ev_t EV_DOUBLE = 2'd2;

  typedef logic [CfgIdxW-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_TAP_THR      = 3'd0;
  localparam cfg_idx_t REG_SECOND_THR   = 3'd1;
  localparam cfg_idx_t REG_STABLE_THR   = 3'd2;
  localparam cfg_idx_t REG_REARM_THR    = 3'd3;
  localparam cfg_idx_t REG_COOLDOWN     = 3'd4;
  localparam cfg_idx_t REG_DBL_WINDOW   = 3'd5;
  localparam cfg_idx_t REG_SWING_IGNORE = 3'd6;
  localparam cfg_idx_t REG_STABLE_TIME  = 3'd7;

  localparam logic [CfgW-1:0] RST_TAP_THR      = 16'd950;
  localparam logic [CfgW-1:0] RST_SECOND_THR   = 16'd450;
  localparam logic [CfgW-1:0] RST_STABLE_THR   = 16'd120;
  localparam logic [CfgW-1:0] RST_REARM_THR    = 16'd180;
  localparam logic [CfgW-1:0] RST_COOLDOWN     = 16'd90;
  localparam logic [CfgW-1:0] RST_DBL_WINDOW   = 16'd650;
  localparam logic [CfgW-1:0] RST_SWING_IGNORE = 16'd700;
  localparam logic [CfgW-1:0] RST_STABLE_TIME  = 16'd180;

  localparam logic [MagW-1:0] BASELINE_RESET = 16'd1000;

  typedef struct packed {
    logic [CfgW-1:0] tap_thr;
    logic [CfgW-1:0] second_thr;
    logic [CfgW-1:0] stable_thr;
    logic [CfgW-1:0] rearm_thr;
    logic [CfgW-1:0] cooldown;
    logic [CfgW-1:0] dbl_window;
    logic [CfgW-1:0] swing_ignore;
    logic [CfgW-1:0] stable_time;
  } cfg_t;

  typedef struct packed {
    cmd_t             command;
    logic [MagW-1:0]  magnitude_mg;
    logic             swing_active;
    logic [TimeW-1:0] now_ms;
  } item_t;

endpackage

// ----- rtl/core/tdt_in_if.sv -----
// ----------------------------------------------------------------------------
// tdt_in_if: input channel of the tap detector
// Valid/ready channel carrying one command with its sample and timestamp.
// ----------------------------------------------------------------------------
interface tdt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [15:0] magnitude_mg;
  logic        swing_active;
  logic [31:0] now_ms;

  modport source (output valid, output command, output magnitude_mg,
                  output swing_active, output now_ms, input ready);
  modport sink   (input valid, input command, input magnitude_mg,
                  input swing_active, input now_ms, output ready);
endinterface

// ----- rtl/core/tdt_out_if.sv -----
// ----------------------------------------------------------------------------
// tdt_out_if: result channel of the tap detector
// Valid/ready channel carrying one tap event per command.
// ----------------------------------------------------------------------------
interface tdt_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] tap_event;

  modport source (output valid, output tap_event, input ready);
  modport sink   (input valid, input tap_event, output ready);
endinterface

// ----- rtl/core/tdt_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// tdt_cfg_regs: configuration register file
// Eight 16-bit thresholds and time limits, written by index.
// ----------------------------------------------------------------------------
module tdt_cfg_regs (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   we_i,
  input  tdt_pkg::cfg_idx_t      idx_i,
  input  logic [tdt_pkg::CfgW-1:0] wdata_i,
  output tdt_pkg::cfg_t          cfg_o
);
  import tdt_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      unique case (idx_i)
        REG_TAP_THR:      cfg_d.tap_thr      = wdata_i;
        REG_SECOND_THR:   cfg_d.second_thr   = wdata_i;
        REG_STABLE_THR:   cfg_d.stable_thr   = wdata_i;
        REG_REARM_THR:    cfg_d.rearm_thr    = wdata_i;
        REG_COOLDOWN:     cfg_d.cooldown     = wdata_i;
        REG_DBL_WINDOW:   cfg_d.dbl_window   = wdata_i;
        REG_SWING_IGNORE: cfg_d.swing_ignore = wdata_i;
        REG_STABLE_TIME:  cfg_d.stable_time  = wdata_i;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tap_thr      <= RST_TAP_THR;
      cfg_q.second_thr   <= RST_SECOND_THR;
      cfg_q.stable_thr   <= RST_STABLE_THR;
      cfg_q.rearm_thr    <= RST_REARM_THR;
      cfg_q.cooldown     <= RST_COOLDOWN;
      cfg_q.dbl_window   <= RST_DBL_WINDOW;
      cfg_q.swing_ignore <= RST_SWING_IGNORE;
      cfg_q.stable_time  <= RST_STABLE_TIME;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- rtl/core/tdt_engine.sv -----
// ----------------------------------------------------------------------------
// tdt_engine: detector state and single-pass evaluation
// Holds baseline, timestamps, flags; evaluates one command per eval_i cycle.
// ----------------------------------------------------------------------------
module tdt_engine #(
  parameter int unsigned BASELINE_SHIFT = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             eval_i,
  input  tdt_pkg::item_t   item_i,
  input  tdt_pkg::cfg_t    cfg_i,
  output tdt_pkg::tap_ev_t ev_o
);
  import tdt_pkg::*;

  localparam logic [MagW:0] RoundAdd = (MagW+1)'((32'd1 << BASELINE_SHIFT) - 32'd1);

  logic [MagW-1:0]  baseline_q, baseline_d;
  logic [TimeW-1:0] last_tap_q, last_tap_d;
  logic [TimeW-1:0] last_swing_q, last_swing_d;
  logic [TimeW-1:0] stable_since_q, stable_since_d;
  logic             armed_q, armed_d;
  logic             awaiting_q, awaiting_d;

  logic [MagW-1:0]  mag;
  logic [TimeW-1:0] now;
  logic             mag_ge;
  logic [MagW-1:0]  dev;
  logic [MagW-1:0]  up_step, dn_step, base_trk;
  logic [MagW:0]    dn_sum;
  logic [TimeW-1:0] since_tap, since_swing, since_stable;
  logic             in_window, was_stable, window_over;
  logic             armed_s;
  tap_ev_t          ev;

  assign mag = item_i.magnitude_mg;
  assign now = item_i.now_ms;

  // deviation from baseline and the baseline tracking step
  assign mag_ge   = mag >= baseline_q;
  assign dev      = mag_ge ? mag - baseline_q : baseline_q - mag;
  assign up_step  = dev >> BASELINE_SHIFT;
  assign dn_sum   = {1'b0, dev} + RoundAdd;
  assign dn_step  = MagW'(dn_sum >> BASELINE_SHIFT);
  assign base_trk = mag_ge ? baseline_q + up_step : baseline_q - dn_step;

  assign since_tap    = now - last_tap_q;
  assign since_swing  = now - last_swing_q;
  assign since_stable = now - stable_since_q;
  assign window_over  = since_tap > TimeW'(cfg_i.dbl_window);
  assign in_window    = awaiting_q && !window_over;
  assign was_stable   = (stable_since_q != '0) &&
                        (since_stable >= TimeW'(cfg_i.stable_time));
  assign armed_s      = armed_q ||
                        ((dev < cfg_i.rearm_thr) && (was_stable || in_window));

  always_comb begin
    baseline_d     = baseline_q;
    last_tap_d     = last_tap_q;
    last_swing_d   = last_swing_q;
    stable_since_d = stable_since_q;
    armed_d        = armed_q;
    awaiting_d     = awaiting_q;
    ev             = EV_NONE;
    if (eval_i) begin
      unique case (item_i.command)
        CMD_SAMPLE: begin
          if (item_i.swing_active) begin
            last_swing_d = now;
            armed_d      = 1'b0;
            awaiting_d   = 1'b0;
          end else begin
            if (dev < cfg_i.stable_thr) begin
              if (stable_since_q == '0) stable_since_d = now;
            end else begin
              stable_since_d = '0;
            end
            if (dev < cfg_i.tap_thr) baseline_d = base_trk;
            armed_d = armed_s;
            if (armed_s && since_tap >= TimeW'(cfg_i.cooldown) &&
                since_swing >= TimeW'(cfg_i.swing_ignore)) begin
              if (awaiting_q) begin
                if (!window_over && dev >= cfg_i.second_thr) begin
                  awaiting_d = 1'b0;
                  armed_d    = 1'b0;
                  last_tap_d = now;
                  ev         = EV_DOUBLE;
                end
              end else if (was_stable && dev >= cfg_i.tap_thr) begin
                armed_d    = 1'b0;
                last_tap_d = now;
                awaiting_d = 1'b1;
              end
            end
          end
        end
        CMD_CHECK: begin
          if (awaiting_q && window_over) begin
            awaiting_d = 1'b0;
            armed_d    = 1'b0;
            ev         = EV_SINGLE;
          end
        end
        CMD_RESTART: begin
          baseline_d     = BASELINE_RESET;
          last_tap_d     = now - TimeW'(cfg_i.cooldown);
          last_swing_d   = now - TimeW'(cfg_i.swing_ignore);
          stable_since_d = now;
          armed_d        = 1'b1;
          awaiting_d     = 1'b0;
        end
        default: begin
          ev = EV_NONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      baseline_q     <= BASELINE_RESET;
      last_tap_q     <= '0 - TimeW'(RST_COOLDOWN);
      last_swing_q   <= '0 - TimeW'(RST_SWING_IGNORE);
      stable_since_q <= '0;
      armed_q        <= 1'b1;
      awaiting_q     <= 1'b0;
    end else begin
      baseline_q     <= baseline_d;
      last_tap_q     <= last_tap_d;
      last_swing_q   <= last_swing_d;
      stable_since_q <= stable_since_d;
      armed_q        <= armed_d;
      awaiting_q     <= awaiting_d;
    end
  end

  assign ev_o = ev;

`ifndef SYNTHESIS
  a_double_needs_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (eval_i && ev == EV_DOUBLE) |-> awaiting_q)
    else $error("double tap reported without a pending first tap");

  a_double_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (eval_i && ev == EV_DOUBLE) |=> (!awaiting_q && !armed_q))
    else $error("double tap left detector armed or pending");

  a_single_from_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (eval_i && ev == EV_SINGLE) |-> (item_i.command == CMD_CHECK && awaiting_q))
    else $error("single tap reported outside a pending check");

  a_restart_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (eval_i && item_i.command == CMD_RESTART) |=>
      (baseline_q == BASELINE_RESET && armed_q && !awaiting_q))
    else $error("restart did not reload the detector state");
`endif

endmodule

// ----- rtl/core/tap_double_tap_detector_top.sv -----
// ----------------------------------------------------------------------------
// tap_double_tap_detector_top: single / double tap detector
// Input register, evaluation engine with configuration, result register.
// ----------------------------------------------------------------------------
// Usage:
//   sample_i carries one command per transfer: a magnitude sample with its
//   swing flag and timestamp, a pending check, or a restart at a given time.
//   event_o returns exactly one tap event per command, in order: none,
//   single tap (from a pending check after the window) or double tap.
//   Configuration: cfg_we_i writes cfg_wdata_i into register cfg_idx_i at
//   the clock edge; write only while no command is in flight.
// Pipeline: a transferred command is held in the input register and is
//   evaluated from it once the result register can take it; its event then
//   shows on event_o from the result register: two register stages in all.
// Throughput: one command per cycle unless the result stalls; the detector
//   state (baseline, times, flags) updates in the same cycle its command is
//   evaluated, so the next command always sees it.
// Reset: all thresholds take their default values, the baseline is 1000 mg,
//   the detector is armed with no pending tap and both pipeline stages empty.
// Stall: when event_o is not taken, the result holds and the input register
//   still accepts one more command; sample_i.ready drops only when both the
//   input register and the result register are full and the result stalls.
// ----------------------------------------------------------------------------
module tap_double_tap_detector_top #(
  parameter int unsigned BASELINE_SHIFT = 4
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  tdt_in_if.sink                      sample_i,
  tdt_out_if.source                   event_o,
  input  logic                        cfg_we_i,
  input  tdt_pkg::cfg_idx_t           cfg_idx_i,
  input  logic [tdt_pkg::CfgW-1:0]    cfg_wdata_i
);
  import tdt_pkg::*;

  cfg_t    cfg;
  item_t   in_q;
  logic    in_valid_q;
  logic    out_valid_q;
  tap_ev_t out_ev_q;
  tap_ev_t ev;
  logic    advance;
  logic    in_take;

  // evaluate the held command whenever the result register can take it
  assign advance = in_valid_q && (!out_valid_q || event_o.ready);
  assign in_take = sample_i.valid && sample_i.ready;

  assign sample_i.ready = !in_valid_q || advance;

  // input register: load on transfer, drop once evaluated
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_take || (in_valid_q && !advance);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q.command      <= sample_i.command;
      in_q.magnitude_mg <= sample_i.magnitude_mg;
      in_q.swing_active <= sample_i.swing_active;
      in_q.now_ms       <= sample_i.now_ms;
    end
  end

  tdt_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_we_i),
    .idx_i   (cfg_idx_i),
    .wdata_i (cfg_wdata_i),
    .cfg_o   (cfg)
  );

  tdt_engine #(
    .BASELINE_SHIFT (BASELINE_SHIFT)
  ) u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .eval_i (advance),
    .item_i (in_q),
    .cfg_i  (cfg),
    .ev_o   (ev)
  );

  // result register: load on evaluation, hold while the receiver stalls
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= advance || (out_valid_q && !event_o.ready);
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) out_ev_q <= ev;
  end

  assign event_o.valid     = out_valid_q;
  assign event_o.tap_event = out_ev_q;

`ifndef SYNTHESIS
  a_eval_fills_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("evaluated command produced no result");

  a_backpressure_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !sample_i.ready |-> (in_valid_q && out_valid_q && !event_o.ready))
    else $error("input stalled without a full pipeline");

  a_drain_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (event_o.valid && event_o.ready && !in_valid_q) |=> !event_o.valid)
    else $error("result appeared without a command to evaluate");
`endif

endmodule
